// ----- hdl/trht_pkg.sv -----
`default_nettype none

package trht_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int COORD_W   = 12;
  localparam int TYPE_W    = 3;
  localparam int HANDLER_W = 8;
  localparam int SLOT_W    = 4;
  localparam int USED_W    = 5;

  typedef enum logic [1:0] {
    KIND_REGISTER   = 2'd0,
    KIND_UNREGISTER = 2'd1,
    KIND_CHECK      = 2'd2,
    KIND_CLEAR      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // swipe events occupy a contiguous code range
  localparam logic [TYPE_W-1:0] EVT_SWIPE_FIRST = 3'd1;
  localparam logic [TYPE_W-1:0] EVT_SWIPE_LAST  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [TYPE_W-1:0]    event_type;
    logic [COORD_W-1:0]   region_x_first;
    logic [COORD_W-1:0]   region_x_last;
    logic [COORD_W-1:0]   region_y_first;
    logic [COORD_W-1:0]   region_y_last;
    logic [COORD_W-1:0]   touch_x;
    logic [COORD_W-1:0]   touch_y;
    logic [HANDLER_W-1:0] handler_in;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [HANDLER_W-1:0] handler_out;
    logic [SLOT_W-1:0]    slot_index;
    logic [USED_W-1:0]    entries_used;
  } out_t;

  typedef struct packed {
    logic [TYPE_W-1:0]    event_type;
    logic [COORD_W-1:0]   x_first;
    logic [COORD_W-1:0]   x_last;
    logic [COORD_W-1:0]   y_first;
    logic [COORD_W-1:0]   y_last;
    logic [HANDLER_W-1:0] handler;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   load;         // evaluate match flags against the incoming item
    logic   upd_handler;  // first matching cell takes the new handler
    logic   append;       // cell at the fill position takes the new entry
    logic   shift;        // cells at and after the hit take their neighbor
    entry_t wr_entry;
  } cell_cmd_t;

  function automatic logic is_swipe(input logic [TYPE_W-1:0] t);
    return (t >= EVT_SWIPE_FIRST) && (t <= EVT_SWIPE_LAST);
  endfunction

  function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, idx};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] cnt_to_slot(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, cnt};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [USED_W-1:0] cnt_to_used(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+USED_W-1:0] w;
    w = {{USED_W{1'b0}}, cnt};
    return w[USED_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/trht_cell.sv -----
`default_nettype none

module trht_cell (
  input  wire                                  clk_i,
  input  wire logic [trht_pkg::IDX_W-1:0]     idx_i,
  input  wire logic [trht_pkg::CNT_W-1:0]     count_i,
  input  wire trht_pkg::in_t                   item_i,
  input  wire trht_pkg::cell_cmd_t             cmd_i,
  input  wire trht_pkg::entry_t                nbr_entry_i,
  output trht_pkg::entry_t                     entry_o,
  input  wire logic                            found_i,
  output logic                                 found_o,
  output logic [trht_pkg::IDX_W-1:0]           slot_o,
  output logic [trht_pkg::HANDLER_W-1:0]       handler_o
);

  trht_pkg::entry_t entry_q;
  logic             match_q, match_d;
  logic             valid, same, in_rect, hit, first;

  assign valid = {{(trht_pkg::CNT_W - trht_pkg::IDX_W){1'b0}}, idx_i} < count_i;

  assign same = (entry_q.event_type == item_i.event_type) &&
                (entry_q.x_first == item_i.region_x_first) &&
                (entry_q.x_last  == item_i.region_x_last)  &&
                (entry_q.y_first == item_i.region_y_first) &&
                (entry_q.y_last  == item_i.region_y_last);

  assign in_rect = (item_i.touch_x >= entry_q.x_first) && (item_i.touch_x <= entry_q.x_last) &&
                   (item_i.touch_y >= entry_q.y_first) && (item_i.touch_y <= entry_q.y_last);

  always_comb begin
    unique case (item_i.kind)
      trht_pkg::KIND_REGISTER:   hit = same;
      trht_pkg::KIND_UNREGISTER: hit = same && (entry_q.handler == item_i.handler_in);
      trht_pkg::KIND_CHECK:      hit = (entry_q.event_type == item_i.event_type) &&
                                       (trht_pkg::is_swipe(entry_q.event_type) || in_rect);
      default:                   hit = 1'b0;
    endcase
    match_d = valid && hit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      match_q <= match_d;
    end
  end

  // priority chain: only the lowest matching cell is the selected one
  assign first   = match_q && !found_i;
  assign found_o = found_i || match_q;

  assign slot_o    = first ? idx_i : '0;
  assign handler_o = first ? entry_q.handler : '0;
  assign entry_o   = entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_handler && first) begin
      entry_q.handler <= cmd_i.wr_entry.handler;
    end else if (cmd_i.append &&
                 ({{(trht_pkg::CNT_W - trht_pkg::IDX_W){1'b0}}, idx_i} == count_i)) begin
      entry_q <= cmd_i.wr_entry;
    end else if (cmd_i.shift && found_o) begin
      entry_q <= nbr_entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/touch_region_handler_table.sv -----
// After its input transfer an item is compared (match flags registered), then updated.
// A new item is taken only after the last is committed; each cell registers its match
// flag in the accept cycle and the priority chain picks and commits in the update state.
// A stalled output holds the update cycle until the result register frees up.
// Reset empties the table (count zero) and clears control; entry contents are
// undefined until written.
`default_nettype none

module touch_region_handler_table (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire trht_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output trht_pkg::out_t      out_data_o
);

  localparam int N = trht_pkg::TABLE_ENTRIES;

  trht_pkg::state_e                  state_q, state_d;
  trht_pkg::in_t                     op_q;
  logic [trht_pkg::CNT_W-1:0]        count_q, count_d;
  trht_pkg::out_t                    out_q, out_d;
  logic                              out_valid_q;
  logic                              in_xfer, exec_fire;
  trht_pkg::cell_cmd_t               cmd;

  trht_pkg::entry_t                  entries [N];
  logic [N:0]                        found;
  logic [trht_pkg::IDX_W-1:0]        cell_slot [N];
  logic [trht_pkg::HANDLER_W-1:0]    cell_handler [N];
  logic [trht_pkg::IDX_W-1:0]        sel_slot;
  logic [trht_pkg::HANDLER_W-1:0]    sel_handler;
  logic                              any_hit;

  assign in_ready_o  = (state_q == trht_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign exec_fire   = (state_q == trht_pkg::ST_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign found[0] = 1'b0;
  assign any_hit  = found[N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    trht_pkg::entry_t nbr;
    if (i == N - 1) begin : g_last
      assign nbr = entries[i];
    end else begin : g_mid
      assign nbr = entries[i+1];
    end

    trht_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (trht_pkg::IDX_W'(i)),
      .count_i     (count_q),
      .item_i      (in_data_i),
      .cmd_i       (cmd),
      .nbr_entry_i (nbr),
      .entry_o     (entries[i]),
      .found_i     (found[i]),
      .found_o     (found[i+1]),
      .slot_o      (cell_slot[i]),
      .handler_o   (cell_handler[i])
    );
  end

  // at most one cell drives nonzero values
  always_comb begin
    sel_slot    = '0;
    sel_handler = '0;
    for (int i = 0; i < N; i++) begin
      sel_slot    = sel_slot | cell_slot[i];
      sel_handler = sel_handler | cell_handler[i];
    end
  end

  always_comb begin
    cmd                     = '0;
    cmd.load                = in_xfer;
    cmd.wr_entry.event_type = op_q.event_type;
    cmd.wr_entry.x_first    = op_q.region_x_first;
    cmd.wr_entry.x_last     = op_q.region_x_last;
    cmd.wr_entry.y_first    = op_q.region_y_first;
    cmd.wr_entry.y_last     = op_q.region_y_last;
    cmd.wr_entry.handler    = op_q.handler_in;

    count_d          = count_q;
    out_d.status     = trht_pkg::STATUS_NOT_FOUND;
    out_d.handler_out = '0;
    out_d.slot_index = '0;

    if (op_q.kind == trht_pkg::KIND_REGISTER) begin
      if (any_hit) begin
        cmd.upd_handler  = exec_fire;
        out_d.status     = trht_pkg::STATUS_OK;
        out_d.slot_index = trht_pkg::idx_to_slot(sel_slot);
      end else if (count_q < trht_pkg::CNT_W'(N)) begin
        cmd.append       = exec_fire;
        out_d.status     = trht_pkg::STATUS_OK;
        out_d.slot_index = trht_pkg::cnt_to_slot(count_q);
        count_d          = count_q + trht_pkg::CNT_W'(1);
      end else begin
        out_d.status     = trht_pkg::STATUS_FULL;
      end
    end else if (count_q == '0) begin
      out_d.status = trht_pkg::STATUS_EMPTY;
    end else begin
      case (op_q.kind)
        trht_pkg::KIND_UNREGISTER: begin
          if (any_hit) begin
            cmd.shift        = exec_fire;
            out_d.status     = trht_pkg::STATUS_OK;
            out_d.slot_index = trht_pkg::idx_to_slot(sel_slot);
            count_d          = count_q - trht_pkg::CNT_W'(1);
          end
        end
        trht_pkg::KIND_CHECK: begin
          if (any_hit) begin
            out_d.status      = trht_pkg::STATUS_OK;
            out_d.handler_out = sel_handler;
            out_d.slot_index  = trht_pkg::idx_to_slot(sel_slot);
          end
        end
        default: begin
          out_d.status = trht_pkg::STATUS_OK;
          count_d      = '0;
        end
      endcase
    end
    out_d.entries_used = trht_pkg::cnt_to_used(count_d);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trht_pkg::ST_IDLE: if (in_xfer)   state_d = trht_pkg::ST_EXEC;
      trht_pkg::ST_EXEC: if (exec_fire) state_d = trht_pkg::ST_IDLE;
      default:                          state_d = trht_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trht_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= in_data_i;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/touch_region_handler_table_tb.sv -----
`default_nettype none

module touch_region_handler_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    trht_pkg::in_t  item;
    bit             typed;
    trht_pkg::out_t result;
  } stim_row_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  trht_pkg::in_t  in_data   = '0;
  logic           in_ready;
  logic           out_valid;
  logic           out_ready = 1'b0;
  trht_pkg::out_t out_data;

  // software copy of the region table
  trht_pkg::entry_t regions [trht_pkg::TABLE_ENTRIES];
  int               n_used = 0;

  trht_pkg::out_t pending_results [$];
  stim_row_t      directed_rows [$];
  int             errors        = 0;
  int             send_idle_pct = 0;
  int             stall_pct     = 0;
  int             hold_reqs     = 0;

  int idle_by_phase  [4] = '{0, 84, 0, 23};
  int stall_by_phase [4] = '{0, 0, 84, 23};

  touch_region_handler_table i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  function automatic bit same_rect(input trht_pkg::entry_t e, input trht_pkg::in_t it);
    return e.event_type == it.event_type && e.x_first == it.region_x_first &&
           e.x_last == it.region_x_last && e.y_first == it.region_y_first &&
           e.y_last == it.region_y_last;
  endfunction

  // updates the table copy and returns the result the block should give
  function automatic trht_pkg::out_t apply_to_regions(input trht_pkg::in_t it);
    trht_pkg::out_t r;
    int             i;
    int             j;
    r        = '0;
    r.status = trht_pkg::STATUS_NOT_FOUND;
    if (it.kind == trht_pkg::KIND_REGISTER) begin
      r.status = trht_pkg::STATUS_FULL;
      for (i = 0; i < n_used; i++) begin
        if (same_rect(regions[i], it)) begin
          regions[i].handler = it.handler_in;
          r.status     = trht_pkg::STATUS_OK;
          r.slot_index = i[trht_pkg::SLOT_W-1:0];
          break;
        end
      end
      if (r.status != trht_pkg::STATUS_OK && n_used < trht_pkg::TABLE_ENTRIES) begin
        regions[n_used] = '{it.event_type, it.region_x_first, it.region_x_last,
                            it.region_y_first, it.region_y_last, it.handler_in};
        r.slot_index = n_used[trht_pkg::SLOT_W-1:0];
        r.status     = trht_pkg::STATUS_OK;
        n_used++;
      end
    end else if (n_used == 0) begin
      r.status = trht_pkg::STATUS_EMPTY;
    end else if (it.kind == trht_pkg::KIND_UNREGISTER) begin
      for (i = 0; i < n_used; i++) begin
        if (same_rect(regions[i], it) && regions[i].handler == it.handler_in) begin
          for (j = i; j + 1 < n_used; j++) regions[j] = regions[j + 1];
          n_used--;
          r.status     = trht_pkg::STATUS_OK;
          r.slot_index = i[trht_pkg::SLOT_W-1:0];
          break;
        end
      end
    end else if (it.kind == trht_pkg::KIND_CHECK) begin
      for (i = 0; i < n_used; i++) begin
        if (regions[i].event_type == it.event_type &&
            ((regions[i].event_type >= trht_pkg::EVT_SWIPE_FIRST &&
              regions[i].event_type <= trht_pkg::EVT_SWIPE_LAST) ||
             (it.touch_x >= regions[i].x_first && it.touch_x <= regions[i].x_last &&
              it.touch_y >= regions[i].y_first && it.touch_y <= regions[i].y_last))) begin
          r.status      = trht_pkg::STATUS_OK;
          r.handler_out = regions[i].handler;
          r.slot_index  = i[trht_pkg::SLOT_W-1:0];
          break;
        end
      end
    end else begin
      n_used   = 0;
      r.status = trht_pkg::STATUS_OK;
    end
    r.entries_used = n_used[trht_pkg::USED_W-1:0];
    return r;
  endfunction

  function automatic trht_pkg::in_t mk_item(
      input trht_pkg::kind_e k, input logic [trht_pkg::TYPE_W-1:0] t,
      input logic [trht_pkg::COORD_W-1:0] x0, input logic [trht_pkg::COORD_W-1:0] x1,
      input logic [trht_pkg::COORD_W-1:0] y0, input logic [trht_pkg::COORD_W-1:0] y1,
      input logic [trht_pkg::COORD_W-1:0] tx, input logic [trht_pkg::COORD_W-1:0] ty,
      input logic [trht_pkg::HANDLER_W-1:0] h);
    return '{k, t, x0, x1, y0, y1, tx, ty, h};
  endfunction

  task automatic add_checked(input trht_pkg::in_t it);
    directed_rows.push_back('{it, 1'b0, trht_pkg::out_t'('0)});
  endtask

  task automatic add_typed(input trht_pkg::in_t it, input trht_pkg::status_e st,
                           input logic [trht_pkg::HANDLER_W-1:0] h,
                           input logic [trht_pkg::SLOT_W-1:0] slot,
                           input logic [trht_pkg::USED_W-1:0] used);
    directed_rows.push_back('{it, 1'b1, trht_pkg::out_t'{st, h, slot, used}});
  endtask

  function automatic logic [trht_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return trht_pkg::COORD_W'($urandom_range((1 << trht_pkg::COORD_W) - 1));
    endcase
  endfunction

  function automatic trht_pkg::in_t with_new_region(input trht_pkg::in_t it);
    logic [trht_pkg::COORD_W-1:0] a, b, c, d;
    a = rand_coord();
    b = rand_coord();
    c = rand_coord();
    d = rand_coord();
    // mostly ordered edges, now and then an inverted rectangle
    if (a > b && $urandom_range(9) != 0) {a, b} = {b, a};
    if (c > d && $urandom_range(9) != 0) {c, d} = {d, c};
    it.region_x_first = a;
    it.region_x_last  = b;
    it.region_y_first = c;
    it.region_y_last  = d;
    if ($urandom_range(15) == 0) it.handler_in = '0;
    return it;
  endfunction

  function automatic trht_pkg::in_t with_region(input trht_pkg::in_t it,
                                                input trht_pkg::entry_t e);
    it.event_type     = e.event_type;
    it.region_x_first = e.x_first;
    it.region_x_last  = e.x_last;
    it.region_y_first = e.y_first;
    it.region_y_last  = e.y_last;
    return it;
  endfunction

  function automatic logic [trht_pkg::COORD_W-1:0] point_in(
      input logic [trht_pkg::COORD_W-1:0] lo, input logic [trht_pkg::COORD_W-1:0] hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return trht_pkg::COORD_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // mostly operations on entries already in the table, the rest random
  function automatic trht_pkg::in_t next_random_item();
    logic [95:0]      raw;
    trht_pkg::in_t    it;
    trht_pkg::entry_t e;
    int               sel;
    bit               have;
    raw  = {$urandom, $urandom, $urandom};
    it   = raw[$bits(trht_pkg::in_t)-1:0];
    sel  = $urandom_range(99);
    have = n_used > 0;
    e    = '0;
    if (have) e = regions[$urandom_range(n_used - 1)];
    if (sel < 45) begin
      it.kind = trht_pkg::KIND_REGISTER;
      if (have && $urandom_range(9) < 3) it = with_region(it, e);
      else it = with_new_region(it);
    end else if (sel < 65) begin
      it.kind = trht_pkg::KIND_UNREGISTER;
      if (have && $urandom_range(9) < 7) begin
        it = with_region(it, e);
        if ($urandom_range(4) != 0) it.handler_in = e.handler;
      end
    end else if (sel < 99) begin
      it.kind    = trht_pkg::KIND_CHECK;
      it.touch_x = rand_coord();
      it.touch_y = rand_coord();
      if (have && $urandom_range(9) < 8) begin
        it.event_type = e.event_type;
        if (e.x_first <= e.x_last && e.y_first <= e.y_last && $urandom_range(3) != 0) begin
          it.touch_x = point_in(e.x_first, e.x_last);
          it.touch_y = point_in(e.y_first, e.y_last);
        end
      end
    end else begin
      it.kind = trht_pkg::KIND_CLEAR;
    end
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_item(input trht_pkg::in_t it, input bit typed,
                           input trht_pkg::out_t typed_res);
    trht_pkg::out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    predicted = apply_to_regions(it);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic field_check(input string name, input logic [trht_pkg::HANDLER_W-1:0] want,
                             input logic [trht_pkg::HANDLER_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    trht_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected transfer, expected none, actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        field_check("status", trht_pkg::HANDLER_W'(want.status),
                    trht_pkg::HANDLER_W'(out_data.status));
        field_check("handler_out", want.handler_out, out_data.handler_out);
        field_check("slot_index", trht_pkg::HANDLER_W'(want.slot_index),
                    trht_pkg::HANDLER_W'(out_data.slot_index));
        field_check("entries_used", trht_pkg::HANDLER_W'(want.entries_used),
                    trht_pkg::HANDLER_W'(out_data.entries_used));
      end
    end
  end

  // output back-pressure; a hold request forces a long stall
  initial begin : receiver
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left  = 100;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = $urandom_range(99) >= stall_pct;
      end
    end
  end

  initial begin : stimulus
    trht_pkg::in_t it;
    int            ph;

    add_typed(mk_item(trht_pkg::KIND_CHECK, 3'd5, 0, 0, 0, 0, 12'd7, 12'd7, 8'd0),
              trht_pkg::STATUS_EMPTY, 8'h00, 4'd0, 5'd0);
    add_typed(mk_item(trht_pkg::KIND_UNREGISTER, 3'd1, 0, 0, 0, 0, 0, 0, 8'd0),
              trht_pkg::STATUS_EMPTY, 8'h00, 4'd0, 5'd0);
    add_typed(mk_item(trht_pkg::KIND_CLEAR, 3'd7, '1, '1, '1, '1, '1, '1, '1),
              trht_pkg::STATUS_EMPTY, 8'h00, 4'd0, 5'd0);
    // type none, whole screen, handler zero
    add_typed(mk_item(trht_pkg::KIND_REGISTER, 3'd0, 0, '1, 0, '1, 0, 0, 8'h00),
              trht_pkg::STATUS_OK, 8'h00, 4'd0, 5'd1);
    add_typed(mk_item(trht_pkg::KIND_CHECK, 3'd0, 0, 0, 0, 0, '1, '1, 8'h12),
              trht_pkg::STATUS_OK, 8'h00, 4'd0, 5'd1);
    // inverted x edges: stored, never hit
    add_typed(mk_item(trht_pkg::KIND_REGISTER, 3'd7, 12'd100, 12'd50, 0, '1, 0, 0, 8'hFF),
              trht_pkg::STATUS_OK, 8'h00, 4'd1, 5'd2);
    add_typed(mk_item(trht_pkg::KIND_CHECK, 3'd7, 0, 0, 0, 0, 12'd75, 12'd10, 8'h00),
              trht_pkg::STATUS_NOT_FOUND, 8'h00, 4'd0, 5'd2);
    add_typed(mk_item(trht_pkg::KIND_REGISTER, 3'd1, 12'd10, 12'd20, 12'd10, 12'd20, 0, 0,
                      8'hAA),
              trht_pkg::STATUS_OK, 8'h00, 4'd2, 5'd3);
    // swipe hits outside its rectangle
    add_typed(mk_item(trht_pkg::KIND_CHECK, 3'd1, 0, 0, 0, 0, '1, 0, 8'h00),
              trht_pkg::STATUS_OK, 8'hAA, 4'd2, 5'd3);
    add_typed(mk_item(trht_pkg::KIND_REGISTER, 3'd1, 12'd10, 12'd20, 12'd10, 12'd20, 0, 0,
                      8'h55),
              trht_pkg::STATUS_OK, 8'h00, 4'd2, 5'd3);
    add_typed(mk_item(trht_pkg::KIND_CHECK, 3'd4, 0, 0, 0, 0, 12'd15, 12'd15, 8'h00),
              trht_pkg::STATUS_NOT_FOUND, 8'h00, 4'd0, 5'd3);
    // old handler no longer matches
    add_typed(mk_item(trht_pkg::KIND_UNREGISTER, 3'd1, 12'd10, 12'd20, 12'd10, 12'd20, 0, 0,
                      8'hAA),
              trht_pkg::STATUS_NOT_FOUND, 8'h00, 4'd0, 5'd3);
    // middle entry goes, the swipe entry closes up
    add_typed(mk_item(trht_pkg::KIND_UNREGISTER, 3'd7, 12'd100, 12'd50, 0, '1, 0, 0, 8'hFF),
              trht_pkg::STATUS_OK, 8'h00, 4'd1, 5'd2);
    add_typed(mk_item(trht_pkg::KIND_CHECK, 3'd1, 0, 0, 0, 0, 0, 0, 8'h00),
              trht_pkg::STATUS_OK, 8'h55, 4'd1, 5'd2);
    add_checked(mk_item(trht_pkg::KIND_CHECK, 3'd0, 0, 0, 0, 0, 12'd2048, 12'd0, 8'h00));
    add_typed(mk_item(trht_pkg::KIND_CLEAR, 3'd0, 0, 0, 0, 0, 0, 0, 8'h00),
              trht_pkg::STATUS_OK, 8'h00, 4'd0, 5'd0);
    add_typed(mk_item(trht_pkg::KIND_CLEAR, 3'd0, 0, 0, 0, 0, 0, 0, 8'h00),
              trht_pkg::STATUS_EMPTY, 8'h00, 4'd0, 5'd0);
    add_typed(mk_item(trht_pkg::KIND_REGISTER, 3'd3, '1, 0, '1, 0, 0, 0, 8'hFF),
              trht_pkg::STATUS_OK, 8'h00, 4'd0, 5'd1);
    add_typed(mk_item(trht_pkg::KIND_CHECK, 3'd3, 0, 0, 0, 0, 12'd1234, 12'd3000, 8'h00),
              trht_pkg::STATUS_OK, 8'hFF, 4'd0, 5'd1);
    add_checked(mk_item(trht_pkg::KIND_CHECK, 3'd6, 12'd5, 12'd6, 12'd7, 12'd8, 12'd1, 12'd1,
                        8'h01));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 23;
    stall_pct     = 23;
    foreach (directed_rows[k])
      push_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].result);
    drain();

    // long output stall while registers keep coming: fills the pipe and the table
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs++;
    repeat (17) begin
      it      = next_random_item();
      it.kind = trht_pkg::KIND_REGISTER;
      push_item(with_new_region(it), 1'b0, '0);
    end
    drain();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      repeat (175) push_item(next_random_item(), 1'b0, '0);
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
